// ----- design/nps_pkg.sv -----
// ---------------------------------------------------------------------------
// nps_pkg
// Shared types, codes and helper functions of the NMEA position parser.
// ---------------------------------------------------------------------------
package nps_pkg;

    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,
        KIND_RMC  = 2'd1,
        KIND_GGA  = 2'd2
    } kind_t;

    // What the parser expects at the current step of a sentence
    typedef enum logic [4:0] {
        CD_COMMA,
        CD_TIME,
        CD_STATUS,
        CD_LAT,
        CD_NS,
        CD_LON,
        CD_EW,
        CD_SPEED,
        CD_COURSE,
        CD_DATE,
        CD_REAL,
        CD_VAREW,
        CD_UNIT,
        CD_QUAL,
        CD_SATS,
        CD_REF,
        CD_DONE,
        CD_HEADER
    } code_t;

    localparam logic [55:0] HDR_RMC = 56'h00_2447_5052_4D43;
    localparam logic [55:0] HDR_GGA = 56'h00_2447_5047_4741;

    localparam logic [7:0] CH_DOLLAR    = 8'h24;
    localparam logic [7:0] CH_STAR      = 8'h2A;
    localparam logic [7:0] CH_COMMA     = 8'h2C;
    localparam logic [7:0] CH_DOT       = 8'h2E;
    localparam logic [7:0] CH_ZERO      = 8'h30;
    localparam logic [7:0] CH_NINE      = 8'h39;
    localparam logic [7:0] CH_BLANK_MAX = 8'd32;
    localparam logic [7:0] CH_HDR_MIN   = 8'd64;

    localparam logic [2:0]  FRAC_KEEP     = 3'd6;
    localparam logic [30:0] ANGLE_MAX     = 31'd1800000000;
    localparam logic [31:0] MAGIC_DIV100  = 32'h51EB_851F;   // x/100 = (x*M) >> 37
    localparam logic [31:0] MAGIC_DIV6    = 32'hAAAA_AAAB;   // x/6   = (x*M) >> 34
    localparam int          CV_STAGES     = 5;

    typedef struct packed {
        logic [31:0] i;     // integer part, ddmm or dddmm
        logic [19:0] f;     // kept fraction digits
        logic [2:0]  d;     // number of kept fraction digits
    } ang_raw_t;

    typedef struct packed {
        ang_raw_t    lat;
        ang_raw_t    lon;
        logic [31:0] utc_raw;
        logic [15:0] speed;
        logic [15:0] course;
        logic [3:0]  qual;
        logic [6:0]  sats;
        logic        stat_a;
        logic        qnz;
        logic        south;
        logic        west;
    } fields_t;

    // Parser state at the sentence end
    typedef struct packed {
        kind_t       kind;
        logic        err;
        logic [4:0]  step;
        logic [1:0]  phase;
        fields_t     f;
    } snap_t;

    typedef struct packed {
        logic [25:0] deg;
        logic [19:0] scl;
        logic [6:0]  mins;
        logic        big;
        logic [7:0]  deg8;
        logic [26:0] x;
        logic [31:0] dm;
        logic [23:0] q;
        logic [30:0] mag;
    } ang_cv_t;

    typedef struct packed {
        snap_t       s;
        logic        ok;
        ang_cv_t     lat;
        ang_cv_t     lon;
        logic [25:0] tq;
        logic [18:0] tq2;
        logic [6:0]  sec;
        logic [6:0]  minute;
        logic [6:0]  hour;
    } cv_t;

    typedef struct packed {
        logic [1:0]         sentence_kind;
        logic               parse_ok;
        logic               fix_valid;
        logic signed [31:0] latitude;
        logic signed [31:0] longitude;
        logic [6:0]         utc_hour;
        logic [6:0]         utc_minute;
        logic [6:0]         utc_second;
        logic [3:0]         fix_quality;
        logic [6:0]         satellites_used;
        logic [15:0]        speed_tenths;
        logic [15:0]        course_tenths;
    } res_t;

    function automatic kind_t hdr_kind(logic [55:0] hdr);
        kind_t k;
        k = KIND_NONE;
        if (hdr == HDR_RMC)
        begin
            k = KIND_RMC;
        end
        else if (hdr == HDR_GGA)
        begin
            k = KIND_GGA;
        end
        return k;
    endfunction

    // Field order of each sentence kind; odd steps before the last field are commas
    function automatic code_t step_code(kind_t kind, logic [4:0] step);
        code_t r;
        r = CD_DONE;
        if (step == 5'd0)
        begin
            r = CD_HEADER;
        end
        else if (kind == KIND_RMC)
        begin
            if (step[0] && step <= 5'd21)
            begin
                r = CD_COMMA;
            end
            else
            begin
                case (step)
                    5'd2:    r = CD_TIME;
                    5'd4:    r = CD_STATUS;
                    5'd6:    r = CD_LAT;
                    5'd8:    r = CD_NS;
                    5'd10:   r = CD_LON;
                    5'd12:   r = CD_EW;
                    5'd14:   r = CD_SPEED;
                    5'd16:   r = CD_COURSE;
                    5'd18:   r = CD_DATE;
                    5'd20:   r = CD_REAL;
                    5'd22:   r = CD_VAREW;
                    default: r = CD_DONE;
                endcase
            end
        end
        else if (kind == KIND_GGA)
        begin
            if (step[0] && step <= 5'd23)
            begin
                r = CD_COMMA;
            end
            else
            begin
                case (step)
                    5'd2:    r = CD_TIME;
                    5'd4:    r = CD_LAT;
                    5'd6:    r = CD_NS;
                    5'd8:    r = CD_LON;
                    5'd10:   r = CD_EW;
                    5'd12:   r = CD_QUAL;
                    5'd14:   r = CD_SATS;
                    5'd16:   r = CD_REAL;
                    5'd18:   r = CD_REAL;
                    5'd20:   r = CD_UNIT;
                    5'd22:   r = CD_REAL;
                    5'd24:   r = CD_REF;
                    default: r = CD_DONE;
                endcase
            end
        end
        return r;
    endfunction

    function automatic logic is_letter(code_t code);
        return code inside {CD_STATUS, CD_NS, CD_EW, CD_VAREW, CD_UNIT};
    endfunction

    function automatic logic is_number(code_t code);
        return !(code inside {CD_COMMA, CD_DONE, CD_HEADER}) && !is_letter(code);
    endfunction

    // Good end: no error, and done or a number in progress closing the last field
    function automatic logic sentence_ok(snap_t s);
        code_t c;
        c = step_code(s.kind, s.step);
        return !s.err && ((c == CD_DONE) ||
               (is_number(c) && s.phase[0] &&
                step_code(s.kind, s.step + 5'd1) == CD_DONE));
    endfunction

endpackage

// ----- design/nps_in_if.sv -----
// ---------------------------------------------------------------------------
// nps_in_if
// Sentence byte channel: one byte and its end-of-sentence mark per word.
// ---------------------------------------------------------------------------
interface nps_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       end_of_sentence;

    modport source (output valid, output char_code, output end_of_sentence, input ready);
    modport sink   (input valid, input char_code, input end_of_sentence, output ready);
endinterface

// ----- design/nps_out_if.sv -----
// ---------------------------------------------------------------------------
// nps_out_if
// Position report channel: one parsed sentence per word.
// ---------------------------------------------------------------------------
interface nps_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         sentence_kind;
    logic               parse_ok;
    logic               fix_valid;
    logic signed [31:0] latitude;
    logic signed [31:0] longitude;
    logic [6:0]         utc_hour;
    logic [6:0]         utc_minute;
    logic [6:0]         utc_second;
    logic [3:0]         fix_quality;
    logic [6:0]         satellites_used;
    logic [15:0]        speed_tenths;
    logic [15:0]        course_tenths;

    modport source (output valid, output sentence_kind, output parse_ok, output fix_valid,
                    output latitude, output longitude, output utc_hour, output utc_minute,
                    output utc_second, output fix_quality, output satellites_used,
                    output speed_tenths, output course_tenths, input ready);
    modport sink   (input valid, input sentence_kind, input parse_ok, input fix_valid,
                    input latitude, input longitude, input utc_hour, input utc_minute,
                    input utc_second, input fix_quality, input satellites_used,
                    input speed_tenths, input course_tenths, output ready);
endinterface

// ----- design/nmea_position_sentence_parser_core.sv -----
// ---------------------------------------------------------------------------
// nmea_position_sentence_parser_core
// NMEA 0183 $GPRMC / $GPGGA position sentence parser.
//
// Takes one sentence byte per word on the sentence channel, with
// end_of_sentence set on the last byte, and returns one report word per
// sentence on the report channel. A byte is taken every cycle unless the
// converter stalls; the per-byte scan is a single registered step, so
// sentences may follow one another with no gap, even a one-byte sentence
// every cycle. A finished sentence passes the scanner's snapshot register,
// the conversion pipeline stages (reciprocal multiplies for /100 and /6) and
// the report register. Up to seven reports can be in flight, so the input
// keeps flowing while the report channel stalls until all of them are full.
// Positions are signed degrees times 1e7 (south and west negative, magnitude
// saturated at 180 degrees); time, quality and satellites come from GGA only,
// speed and course (tenths, truncated) from RMC only; fields outside the
// sentence kind, and all but sentence_kind when parse_ok is low, are zero.
// ---------------------------------------------------------------------------
module nmea_position_sentence_parser_core
    import nps_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    nps_in_if.sink    sentence,
    nps_out_if.source report
);

    snap_t snap;
    logic  snap_valid;
    logic  snap_ready;
    cv_t   cv;
    logic  cv_valid;
    logic  cv_ready;

    res_t  res_next;
    res_t  res_reg;
    logic  out_valid_reg;

    // byte scanner: header match, field order, digit accumulation
    nps_char_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .sentence   (sentence),
        .snap       (snap),
        .snap_valid (snap_valid),
        .snap_ready (snap_ready)
    );

    // conversion pipeline with its own bubble-collapsing valid chain
    nps_convert u_convert (
        .clk        (clk),
        .rst_n      (rst_n),
        .snap       (snap),
        .snap_valid (snap_valid),
        .snap_ready (snap_ready),
        .cv         (cv),
        .cv_valid   (cv_valid),
        .cv_ready   (cv_ready)
    );

    // report register: empty, or the consumer takes the current word
    assign cv_ready = !out_valid_reg || report.ready;

    // sign, per-kind field selection and zeroing on a failed parse
    always_comb
    begin
        res_next               = '0;
        res_next.sentence_kind = cv.s.kind;
        res_next.parse_ok      = cv.ok;
        if (cv.ok)
        begin
            res_next.latitude  = cv.s.f.south ? -$signed({1'b0, cv.lat.mag})
                                              :  $signed({1'b0, cv.lat.mag});
            res_next.longitude = cv.s.f.west  ? -$signed({1'b0, cv.lon.mag})
                                              :  $signed({1'b0, cv.lon.mag});
            if (cv.s.kind == KIND_RMC)
            begin
                res_next.fix_valid     = cv.s.f.stat_a;
                res_next.speed_tenths  = cv.s.f.speed;
                res_next.course_tenths = cv.s.f.course;
            end
            else
            begin
                res_next.fix_valid       = cv.s.f.qnz;
                res_next.utc_hour        = cv.hour;
                res_next.utc_minute      = cv.minute;
                res_next.utc_second      = cv.sec;
                res_next.fix_quality     = cv.s.f.qual;
                res_next.satellites_used = cv.s.f.sats;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cv_ready)
        begin
            out_valid_reg <= cv_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cv_ready)
        begin
            res_reg <= res_next;
        end
    end

    assign report.valid           = out_valid_reg;
    assign report.sentence_kind   = res_reg.sentence_kind;
    assign report.parse_ok        = res_reg.parse_ok;
    assign report.fix_valid       = res_reg.fix_valid;
    assign report.latitude        = res_reg.latitude;
    assign report.longitude       = res_reg.longitude;
    assign report.utc_hour        = res_reg.utc_hour;
    assign report.utc_minute      = res_reg.utc_minute;
    assign report.utc_second      = res_reg.utc_second;
    assign report.fix_quality     = res_reg.fix_quality;
    assign report.satellites_used = res_reg.satellites_used;
    assign report.speed_tenths    = res_reg.speed_tenths;
    assign report.course_tenths   = res_reg.course_tenths;

endmodule

// ----- design/nps_char_parser.sv -----
// ---------------------------------------------------------------------------
// nps_char_parser
// Per-byte sentence scanner; hands the sentence state on at the end byte.
// ---------------------------------------------------------------------------
module nps_char_parser
    import nps_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    nps_in_if.sink     sentence,
    output snap_t      snap,
    output logic       snap_valid,
    input  logic       snap_ready
);

    logic [4:0]  step_reg, step_next;
    logic [1:0]  phase_reg, phase_next;
    logic        err_reg, err_next;
    logic [55:0] hdr_reg, hdr_next;
    logic [31:0] num_reg, num_next;
    logic [19:0] frac_reg, frac_next;
    logic [2:0]  fcnt_reg, fcnt_next;
    logic [3:0]  fd1_reg, fd1_next;
    fields_t     fld_reg, fld_next;
    snap_t       snap_reg;
    logic        snap_valid_reg;

    logic        ready;
    logic        accept;
    logic [7:0]  c;
    logic        blank;
    logic        digit;
    logic [3:0]  dval;
    kind_t       kind_cur;
    code_t       code;
    code_t       pcode;
    logic [1:0]  ph_e;
    logic        do_adv;
    logic        do_post;
    logic        do_finish;
    logic [35:0] acc;

    function automatic logic [7:0] letter_first(code_t cd);
        logic [7:0] r;
        case (cd)
            CD_STATUS: r = 8'h56;   // V
            CD_NS:     r = 8'h4E;   // N
            CD_UNIT:   r = 8'h4D;   // M
            default:   r = 8'h45;   // E
        endcase
        return r;
    endfunction

    function automatic logic [7:0] letter_second(code_t cd);
        logic [7:0] r;
        case (cd)
            CD_STATUS: r = 8'h41;   // A
            CD_NS:     r = 8'h53;   // S
            CD_UNIT:   r = 8'h6D;   // m
            default:   r = 8'h57;   // W
        endcase
        return r;
    endfunction

    function automatic logic has_frac(code_t cd);
        return cd inside {CD_TIME, CD_LAT, CD_LON, CD_SPEED, CD_COURSE, CD_REAL};
    endfunction

    // whole*10 + first fraction digit, saturated
    function automatic logic [15:0] tenths(logic [31:0] whole, logic [3:0] fd,
                                           logic [2:0] cnt);
        logic [16:0] v;
        logic [15:0] r;
        v = 17'(whole[12:0]) * 17'd10 + ((cnt != 3'd0) ? 17'(fd) : 17'd0);
        if (whole[31:13] != 19'd0 || v[16])
        begin
            r = 16'hFFFF;
        end
        else
        begin
            r = v[15:0];
        end
        return r;
    endfunction

    assign ready  = !snap_valid_reg || snap_ready;
    assign accept = sentence.valid && ready;
    assign sentence.ready = ready;

    assign c        = sentence.char_code;
    assign blank    = (c <= CH_BLANK_MAX);
    assign digit    = (c >= CH_ZERO) && (c <= CH_NINE);
    assign dval     = c[3:0];
    assign kind_cur = hdr_kind(hdr_reg);
    assign code     = step_code(kind_cur, step_reg);
    assign pcode    = step_code(kind_cur, step_reg + 5'd1);
    assign acc      = {4'd0, num_reg} * 36'd10 + 36'(dval);

    always_comb
    begin
        step_next  = step_reg;
        phase_next = phase_reg;
        err_next   = err_reg;
        hdr_next   = hdr_reg;
        num_next   = num_reg;
        frac_next  = frac_reg;
        fcnt_next  = fcnt_reg;
        fd1_next   = fd1_reg;
        fld_next   = fld_reg;
        ph_e       = phase_reg | 2'd1;
        do_adv     = 1'b0;
        do_post    = 1'b0;
        do_finish  = 1'b0;

        if (!err_reg)
        begin
            case (code)
                CD_HEADER:
                begin
                    if (hdr_reg[55:48] == 8'd0 && (c == CH_DOLLAR || c >= CH_HDR_MIN))
                    begin
                        hdr_next = {hdr_reg[47:0], c};
                    end
                    else if (blank && hdr_reg == 56'd0)
                    begin
                        hdr_next = hdr_reg;
                    end
                    else if (kind_cur == KIND_NONE)
                    begin
                        err_next = 1'b1;
                    end
                    else
                    begin
                        do_adv  = 1'b1;
                        do_post = 1'b1;
                    end
                end
                CD_DONE:
                begin
                    step_next = step_reg;
                end
                CD_COMMA:
                begin
                    if (c == CH_COMMA)
                    begin
                        step_next = step_reg + 5'd1;
                    end
                    else if (!blank)
                    begin
                        err_next = 1'b1;
                    end
                end
                CD_STATUS, CD_NS, CD_EW, CD_VAREW, CD_UNIT:
                begin
                    // empty field: take the first letter, leave the byte
                    if (phase_reg == 2'd0 && (c == CH_COMMA || c == CH_STAR))
                    begin
                        do_adv  = 1'b1;
                        do_post = 1'b1;
                    end
                    else if (blank)
                    begin
                        phase_next = 2'd1;
                    end
                    else if (c == letter_first(code))
                    begin
                        do_adv = 1'b1;
                    end
                    else if (c == letter_second(code))
                    begin
                        do_adv = 1'b1;
                        case (code)
                            CD_STATUS: fld_next.stat_a = 1'b1;
                            CD_NS:     fld_next.south  = 1'b1;
                            CD_EW:     fld_next.west   = 1'b1;
                            default:   fld_next.stat_a = fld_reg.stat_a;
                        endcase
                    end
                    else
                    begin
                        err_next = 1'b1;
                    end
                end
                default:
                begin
                    if (!(phase_reg[0] == 1'b0 && blank))
                    begin
                        if (ph_e == 2'd1)
                        begin
                            if (digit)
                            begin
                                num_next   = (acc[35:32] != 4'd0) ? 32'hFFFF_FFFF : acc[31:0];
                                phase_next = 2'd1;
                            end
                            else if (c == CH_DOT && has_frac(code))
                            begin
                                phase_next = 2'd2;
                            end
                            else
                            begin
                                do_finish = 1'b1;
                                do_adv    = 1'b1;
                                do_post   = 1'b1;
                            end
                        end
                        else
                        begin
                            if (digit)
                            begin
                                if (fcnt_reg < FRAC_KEEP)
                                begin
                                    frac_next = frac_reg * 20'd10 + 20'(dval);
                                    fcnt_next = fcnt_reg + 3'd1;
                                    if (fcnt_reg == 3'd0)
                                    begin
                                        fd1_next = dval;
                                    end
                                end
                                phase_next = 2'd3;
                            end
                            else
                            begin
                                do_finish = 1'b1;
                                do_adv    = 1'b1;
                                do_post   = 1'b1;
                            end
                        end
                    end
                end
            endcase

            if (do_finish)
            begin
                case (code)
                    CD_TIME:   fld_next.utc_raw = num_reg;
                    CD_LAT:    fld_next.lat = '{i: num_reg, f: frac_reg, d: fcnt_reg};
                    CD_LON:    fld_next.lon = '{i: num_reg, f: frac_reg, d: fcnt_reg};
                    CD_SPEED:  fld_next.speed  = tenths(num_reg, fd1_reg, fcnt_reg);
                    CD_COURSE: fld_next.course = tenths(num_reg, fd1_reg, fcnt_reg);
                    CD_QUAL:
                    begin
                        fld_next.qual = (num_reg > 32'd15) ? 4'd15 : num_reg[3:0];
                        fld_next.qnz  = fld_reg.qnz | (num_reg != 32'd0);
                    end
                    CD_SATS:   fld_next.sats = (num_reg > 32'd99) ? 7'd99 : num_reg[6:0];
                    default:   fld_next.sats = fld_reg.sats;
                endcase
            end

            if (do_adv)
            begin
                step_next  = step_reg + 5'd1;
                phase_next = 2'd0;
                num_next   = 32'd0;
                frac_next  = 20'd0;
                fcnt_next  = 3'd0;
                fd1_next   = 4'd0;
            end

            // same byte again, now against the comma that follows the field
            if (do_post && pcode != CD_DONE)
            begin
                if (c == CH_COMMA)
                begin
                    step_next = step_reg + 5'd2;
                end
                else if (!blank)
                begin
                    err_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg       <= 5'd0;
            phase_reg      <= 2'd0;
            err_reg        <= 1'b0;
            hdr_reg        <= 56'd0;
            num_reg        <= 32'd0;
            frac_reg       <= 20'd0;
            fcnt_reg       <= 3'd0;
            fd1_reg        <= 4'd0;
            fld_reg        <= '0;
            snap_valid_reg <= 1'b0;
        end
        else
        begin
            if (ready)
            begin
                snap_valid_reg <= accept && sentence.end_of_sentence;
            end
            if (accept)
            begin
                if (sentence.end_of_sentence)
                begin
                    step_reg  <= 5'd0;
                    phase_reg <= 2'd0;
                    err_reg   <= 1'b0;
                    hdr_reg   <= 56'd0;
                    num_reg   <= 32'd0;
                    frac_reg  <= 20'd0;
                    fcnt_reg  <= 3'd0;
                    fd1_reg   <= 4'd0;
                    fld_reg   <= '0;
                end
                else
                begin
                    step_reg  <= step_next;
                    phase_reg <= phase_next;
                    err_reg   <= err_next;
                    hdr_reg   <= hdr_next;
                    num_reg   <= num_next;
                    frac_reg  <= frac_next;
                    fcnt_reg  <= fcnt_next;
                    fd1_reg   <= fd1_next;
                    fld_reg   <= fld_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && sentence.end_of_sentence)
        begin
            snap_reg.kind  <= hdr_kind(hdr_next);
            snap_reg.err   <= err_next;
            snap_reg.step  <= step_next;
            snap_reg.phase <= phase_next;
            snap_reg.f     <= fld_next;
        end
    end

    assign snap       = snap_reg;
    assign snap_valid = snap_valid_reg;

endmodule

// ----- design/nps_convert.sv -----
// ---------------------------------------------------------------------------
// nps_convert
// Pipelined unit conversion: ddmm.mmmm to degrees*1e7, hhmmss split.
// ---------------------------------------------------------------------------
module nps_convert
    import nps_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  snap_t snap,
    input  logic  snap_valid,
    output logic  snap_ready,
    output cv_t   cv,
    output logic  cv_valid,
    input  logic  cv_ready
);

    cv_t                  cv_reg  [CV_STAGES];
    cv_t                  cv_next [CV_STAGES];
    logic [CV_STAGES-1:0] v_reg;
    logic [CV_STAGES-1:0] v_in;
    logic [CV_STAGES:0]   rdy;

    function automatic logic [25:0] div100(logic [31:0] x);
        logic [63:0] p;
        p = 64'(x) * 64'(MAGIC_DIV100);
        return p[62:37];
    endfunction

    function automatic logic [6:0] rem100(logic [31:0] x, logic [25:0] q);
        logic [31:0] t;
        t = x - 32'(q) * 32'd100;
        return t[6:0];
    endfunction

    function automatic logic [23:0] div6(logic [26:0] x);
        logic [63:0] p;
        p = 64'(x) * 64'(MAGIC_DIV6);
        return p[57:34];
    endfunction

    // 10^(6-d): brings the kept fraction to six digits
    function automatic logic [19:0] scale_of(logic [2:0] d);
        logic [19:0] r;
        case (d)
            3'd0:    r = 20'd1000000;
            3'd1:    r = 20'd100000;
            3'd2:    r = 20'd10000;
            3'd3:    r = 20'd1000;
            3'd4:    r = 20'd100;
            3'd5:    r = 20'd10;
            default: r = 20'd1;
        endcase
        return r;
    endfunction

    function automatic ang_cv_t ang_s0(ang_raw_t r);
        ang_cv_t a;
        a     = '0;
        a.deg = div100(r.i);
        a.scl = 20'(40'(r.f) * 40'(scale_of(r.d)));
        return a;
    endfunction

    function automatic ang_cv_t ang_s1(ang_cv_t a_in, ang_raw_t r);
        ang_cv_t a;
        a      = a_in;
        a.mins = rem100(r.i, a_in.deg);
        a.big  = a_in.deg > 26'd180;
        a.deg8 = a_in.deg[7:0];
        return a;
    endfunction

    // minutes as millionths: floor(minutes*1e7/60) = x/6
    function automatic ang_cv_t ang_s2(ang_cv_t a_in);
        ang_cv_t a;
        a    = a_in;
        a.x  = 27'(a_in.mins) * 27'd1000000 + 27'(a_in.scl);
        a.dm = 32'(a_in.deg8) * 32'd10000000;
        return a;
    endfunction

    function automatic ang_cv_t ang_s3(ang_cv_t a_in);
        ang_cv_t a;
        a   = a_in;
        a.q = div6(a_in.x);
        return a;
    endfunction

    function automatic ang_cv_t ang_s4(ang_cv_t a_in);
        ang_cv_t     a;
        logic [32:0] sum;
        a   = a_in;
        sum = 33'(a_in.dm) + 33'(a_in.q);
        if (a_in.big || sum > 33'(ANGLE_MAX))
        begin
            a.mag = ANGLE_MAX;
        end
        else
        begin
            a.mag = sum[30:0];
        end
        return a;
    endfunction

    always_comb
    begin
        cv_next[0]     = '0;
        cv_next[0].s   = snap;
        cv_next[0].ok  = sentence_ok(snap);
        cv_next[0].lat = ang_s0(snap.f.lat);
        cv_next[0].lon = ang_s0(snap.f.lon);
        cv_next[0].tq  = div100(snap.f.utc_raw);

        cv_next[1]     = cv_reg[0];
        cv_next[1].lat = ang_s1(cv_reg[0].lat, cv_reg[0].s.f.lat);
        cv_next[1].lon = ang_s1(cv_reg[0].lon, cv_reg[0].s.f.lon);
        cv_next[1].sec = rem100(cv_reg[0].s.f.utc_raw, cv_reg[0].tq);
        cv_next[1].tq2 = 19'(div100(32'(cv_reg[0].tq)));

        cv_next[2]        = cv_reg[1];
        cv_next[2].lat    = ang_s2(cv_reg[1].lat);
        cv_next[2].lon    = ang_s2(cv_reg[1].lon);
        cv_next[2].minute = rem100(32'(cv_reg[1].tq), 26'(cv_reg[1].tq2));
        cv_next[2].hour   = (cv_reg[1].tq2 > 19'd99) ? 7'd99 : cv_reg[1].tq2[6:0];

        cv_next[3]     = cv_reg[2];
        cv_next[3].lat = ang_s3(cv_reg[2].lat);
        cv_next[3].lon = ang_s3(cv_reg[2].lon);

        cv_next[4]     = cv_reg[3];
        cv_next[4].lat = ang_s4(cv_reg[3].lat);
        cv_next[4].lon = ang_s4(cv_reg[3].lon);
    end

    // a stage takes new data when it is empty or its word moves on
    always_comb
    begin
        rdy[CV_STAGES] = cv_ready;
        for (int k = CV_STAGES - 1; k >= 0; k--)
        begin
            rdy[k] = !v_reg[k] || rdy[k + 1];
        end
    end

    assign v_in = {v_reg[CV_STAGES-2:0], snap_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < CV_STAGES; k++)
            begin
                if (rdy[k])
                begin
                    v_reg[k] <= v_in[k];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < CV_STAGES; k++)
        begin
            if (rdy[k])
            begin
                cv_reg[k] <= cv_next[k];
            end
        end
    end

    assign snap_ready = rdy[0];
    assign cv         = cv_reg[CV_STAGES-1];
    assign cv_valid   = v_reg[CV_STAGES-1];

endmodule
